FILE: design/chunk_rms_db_meter_core_assert.svh
// assertion macros for the chunk level meter checker
// no dependencies; pulled in by the checker file
`ifndef CHUNK_RMS_DB_METER_CORE_ASSERT_SVH
`define CHUNK_RMS_DB_METER_CORE_ASSERT_SVH

// consequent in the same cycle, idle while reset is asserted
`define CRDM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the next cycle, idle while reset is asserted
`define CRDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent in the next cycle, checked through reset as well
`define CRDM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/crdm_pkg.sv
// shared types, constants and the log2 fraction table of the chunk level meter
// no dependencies
`default_nettype none

package crdm_pkg;

    localparam int QUEUE_DEPTH      = 4;
    localparam int APB_ADDR_W       = 4;

    localparam int CHUNK_LEN_RESET  = 200;
    localparam int CPB_RESET        = 80;
    localparam int THRESHOLD_RESET  = 800;

    localparam logic [1:0] REG_CHUNK_LEN        = 2'd0;
    localparam logic [1:0] REG_CHUNKS_PER_BLOCK = 2'd1;
    localparam logic [1:0] REG_LOUD_THRESHOLD   = 2'd2;

    // round(160 * log10(2) * 2^16): q16 log2 difference to 1/16 dB in q32
    localparam logic [21:0] LOG_K = 22'd3156528;

    localparam int LEVEL_MIN  = -2048;
    localparam int LEVEL_MAX  = 2047;
    localparam int ROW_CENTER = 30;
    localparam int ROW_MAX    = 63;
    localparam int HALF_STEP  = 20;
    localparam int RECIP_FIVE = 205;

    typedef struct packed {
        logic [7:0] index;
        logic       last;
    } chunk_tag_t;

    typedef struct packed {
        logic signed [11:0] level_db;
        logic               loud;
        logic               silent;
        logic [5:0]         bar_row;
        chunk_tag_t         tag;
    } level_result_t;

    // round(65536 * log2(1 + i/16))
    function automatic logic [16:0] log_frac(input logic [4:0] idx);
        logic [16:0] val;
        case (idx)
            5'd0:    val = 17'd0;
            5'd1:    val = 17'd5732;
            5'd2:    val = 17'd11136;
            5'd3:    val = 17'd16248;
            5'd4:    val = 17'd21098;
            5'd5:    val = 17'd25711;
            5'd6:    val = 17'd30109;
            5'd7:    val = 17'd34312;
            5'd8:    val = 17'd38336;
            5'd9:    val = 17'd42196;
            5'd10:   val = 17'd45904;
            5'd11:   val = 17'd49472;
            5'd12:   val = 17'd52911;
            5'd13:   val = 17'd56229;
            5'd14:   val = 17'd59434;
            5'd15:   val = 17'd62534;
            default: val = 17'd65536;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

FILE: design/crdm_front.sv
// front end: squares samples, counts chunks and blocks, closes each chunk sum
// depends on crdm_pkg
`default_nettype none

module crdm_front import crdm_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int LEN_BITS    = 12
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_valid,
    input  wire logic [SAMPLE_BITS-1:0]              in_sample,
    output logic                                     in_ready,
    input  wire logic [LEN_BITS-1:0]                 cfg_chunk_len,
    input  wire logic [7:0]                          cfg_chunks_per_block,
    input  wire logic                                queue_afull,
    output logic                                     push_valid,
    output logic [2*SAMPLE_BITS+LEN_BITS-1:0]        push_sum,
    output chunk_tag_t                               push_tag
);

    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int SUM_W = SQ_W + LEN_BITS;

    logic [LEN_BITS-1:0]    count_reg, count_next;
    logic [7:0]             chunk_reg, chunk_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic                   sq_valid_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic                   sq_end_reg;
    chunk_tag_t             tag_reg;

    logic                   accept;
    logic [LEN_BITS-1:0]    len_eff;
    logic [7:0]             cpb_eff;
    logic                   chunk_end;
    logic                   block_end;
    logic signed [SQ_W-1:0] square;
    logic [SUM_W-1:0]       total;

    // one transaction in flight in the square stage may still push
    assign in_ready = !queue_afull;
    assign accept   = in_valid && in_ready;

    assign len_eff   = (cfg_chunk_len == '0) ? LEN_BITS'(1) : cfg_chunk_len;
    assign cpb_eff   = (cfg_chunks_per_block == 8'd0) ? 8'd1 : cfg_chunks_per_block;
    assign chunk_end = ({1'b0, count_reg} + (LEN_BITS+1)'(1)) >= {1'b0, len_eff};
    assign block_end = ({1'b0, chunk_reg} + 9'd1) >= {1'b0, cpb_eff};
    assign square    = $signed(in_sample) * $signed(in_sample);

    always_comb begin
        count_next = count_reg;
        chunk_next = chunk_reg;
        if (accept) begin
            if (chunk_end) begin
                count_next = '0;
                chunk_next = block_end ? 8'd0 : chunk_reg + 8'd1;
            end else begin
                count_next = count_reg + LEN_BITS'(1);
            end
        end
    end

    assign total = sum_reg + SUM_W'(sq_reg);

    always_comb begin
        sum_next = sum_reg;
        if (sq_valid_reg) begin
            sum_next = sq_end_reg ? '0 : total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            chunk_reg    <= '0;
            sum_reg      <= '0;
            sq_valid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            chunk_reg    <= chunk_next;
            sum_reg      <= sum_next;
            sq_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sq_reg        <= SQ_W'(square);
            sq_end_reg    <= chunk_end;
            tag_reg.index <= chunk_reg;
            tag_reg.last  <= block_end;
        end
    end

    assign push_valid = sq_valid_reg && sq_end_reg;
    assign push_sum   = total;
    assign push_tag   = tag_reg;

endmodule

`default_nettype wire

FILE: design/crdm_fifo.sv
// short queue of closed chunk sums between the front and the level pipeline
// depends on crdm_pkg
`default_nettype none

module crdm_fifo import crdm_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_valid,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_ready,
    output logic                  rd_valid,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  almost_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign rd_valid    = (count_reg != '0);
    assign rd_data     = entry_reg[rd_ptr_reg];
    assign almost_full = (count_reg >= CNT_W'(DEPTH - 1));

    assign do_wr = wr_valid && (count_reg != CNT_W'(DEPTH));
    assign do_rd = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: design/crdm_back.sv
// level pipeline: two-step normalize, log2 table lookup, scale to 1/16 dB,
// saturate, then flags and bar row into the output register; uses crdm_pkg
`default_nettype none

module crdm_back import crdm_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int LEN_BITS    = 12
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_valid,
    input  wire logic [2*SAMPLE_BITS+LEN_BITS-1:0]   in_sum,
    input  wire chunk_tag_t                          in_tag,
    output logic                                     in_ready,
    input  wire logic [LEN_BITS-1:0]                 cfg_chunk_len,
    input  wire logic signed [11:0]                  cfg_loud_threshold,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output level_result_t                            out_result
);

    localparam int SUM_W  = 2 * SAMPLE_BITS + LEN_BITS;
    localparam int BASE_W = (SUM_W > 21) ? SUM_W : 21;
    localparam int NW     = ((BASE_W + 7) / 8) * 8;
    localparam int NG     = NW / 8;
    localparam int GW     = $clog2(NG);
    localparam int PW     = GW + 3;
    localparam int LPW    = $clog2(LEN_BITS);
    localparam int DW     = PW + 18;
    localparam int PRW    = DW + 23;
    localparam int RW     = PRW - 32;

    localparam logic signed [RW-1:0] R_MIN = RW'(LEVEL_MIN);
    localparam logic signed [RW-1:0] R_MAX = RW'(LEVEL_MAX);

    // log2 fraction in q16 from the 20 bits under the leading one
    function automatic logic [16:0] frac_interp(input logic [19:0] frac);
        logic [16:0] lo;
        logic [16:0] hi;
        logic [12:0] step;
        logic [28:0] prod;
        lo   = log_frac({1'b0, frac[19:16]});
        hi   = log_frac({1'b0, frac[19:16]} + 5'd1);
        step = 13'(hi - lo);
        prod = step * frac[15:0];
        return lo + 17'(prod[28:16]);
    endfunction

    logic adv;

    // stage a: coarse byte normalize of the sum, full normalize of the length
    logic                a_valid_reg;
    chunk_tag_t          a_tag_reg;
    logic                a_silent_reg;
    logic [NW-1:0]       a_coarse_reg;
    logic [GW-1:0]       a_grp_reg;
    logic [LPW-1:0]      a_lp_reg;
    logic [19:0]         a_lfrac_reg;

    logic [NW-1:0]       x_ext;
    logic [GW-1:0]       grp;
    logic [NW-1:0]       coarse;
    logic [LEN_BITS-1:0] len_eff;
    logic [LPW-1:0]      lp;
    logic [LEN_BITS-1:0] lnorm;
    logic [LEN_BITS+19:0] lx;

    // stage b: bit normalize inside the top byte
    logic                b_valid_reg;
    chunk_tag_t          b_tag_reg;
    logic                b_silent_reg;
    logic [PW-1:0]       b_p_reg;
    logic [19:0]         b_sfrac_reg;
    logic [LPW-1:0]      b_lp_reg;
    logic [19:0]         b_lfrac_reg;

    logic [7:0]          top_byte;
    logic [2:0]          bpos;
    logic [NW-1:0]       norm;

    // stage c: table interpolation for both logs
    logic                c_valid_reg;
    chunk_tag_t          c_tag_reg;
    logic                c_silent_reg;
    logic [PW-1:0]       c_p_reg;
    logic [LPW-1:0]      c_lp_reg;
    logic [16:0]         c_fs_reg;
    logic [16:0]         c_fl_reg;

    // stage d: q16 log difference
    logic                d_valid_reg;
    chunk_tag_t          d_tag_reg;
    logic                d_silent_reg;
    logic signed [DW-1:0] d_diff_reg;

    logic signed [PW:0]   pd;
    logic signed [DW-1:0] hi_part;
    logic signed [DW-1:0] diff;

    // stage e: scale by the db constant
    logic                 e_valid_reg;
    chunk_tag_t           e_tag_reg;
    logic                 e_silent_reg;
    logic signed [PRW-1:0] e_prod_reg;
    logic signed [22:0]    k_s;

    // stage f: round and saturate
    logic                 f_valid_reg;
    chunk_tag_t           f_tag_reg;
    logic                 f_silent_reg;
    logic signed [11:0]   f_level_reg;

    logic signed [PRW-1:0] rounded;
    logic signed [RW-1:0]  rv;
    logic signed [11:0]    level;

    // output register
    logic                 out_valid_reg;
    level_result_t        out_result_reg;

    logic [12:0]          mag;
    logic [8:0]           eighth;
    logic [16:0]          qprod;
    logic [5:0]           q;
    logic signed [7:0]    row_s;
    logic [5:0]           row;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_comb begin
        x_ext = NW'(in_sum);
        grp   = '0;
        for (int g = 0; g < NG; g++) begin
            if (x_ext[8*g +: 8] != 8'h00) begin
                grp = GW'(g);
            end
        end
        coarse = x_ext << {GW'(NG - 1) - grp, 3'b000};

        len_eff = (cfg_chunk_len == '0) ? LEN_BITS'(1) : cfg_chunk_len;
        lp      = '0;
        for (int i = 0; i < LEN_BITS; i++) begin
            if (len_eff[i]) begin
                lp = LPW'(i);
            end
        end
        lnorm = len_eff << (LPW'(LEN_BITS - 1) - lp);
        lx    = {lnorm, 20'h00000};
    end

    always_comb begin
        top_byte = a_coarse_reg[NW-1 -: 8];
        bpos     = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (top_byte[i]) begin
                bpos = 3'(i);
            end
        end
        norm = a_coarse_reg << (3'd7 - bpos);
    end

    always_comb begin
        pd      = $signed({1'b0, c_p_reg}) - $signed({1'b0, PW'(c_lp_reg)});
        hi_part = {pd[PW], pd, 16'h0000};
        diff    = hi_part + $signed(DW'(c_fs_reg)) - $signed(DW'(c_fl_reg));
    end

    assign k_s = $signed({1'b0, LOG_K});

    always_comb begin
        rounded = e_prod_reg + $signed(PRW'({1'b1, 31'h0}));
        rv      = $signed(rounded[PRW-1:32]);
        if (e_silent_reg) begin
            level = 12'(LEVEL_MIN);
        end else if (rv < R_MIN) begin
            level = 12'(LEVEL_MIN);
        end else if (rv > R_MAX) begin
            level = 12'(LEVEL_MAX);
        end else begin
            level = rv[11:0];
        end
    end

    // round(|level| / 40) as ((|level| + 20) >> 3) / 5, the /5 by reciprocal
    always_comb begin
        mag    = f_level_reg[11] ? (13'd0 - {1'b1, f_level_reg}) : {1'b0, f_level_reg};
        eighth = 9'((mag + 13'(HALF_STEP)) >> 3);
        qprod  = 17'(eighth) * 17'(RECIP_FIVE);
        q      = qprod[15:10];
        row_s  = f_level_reg[11] ? $signed(8'(ROW_CENTER) + {2'b00, q})
                                 : $signed(8'(ROW_CENTER) - {2'b00, q});
        if (row_s < 8'sd0) begin
            row = 6'd0;
        end else if (row_s > $signed(8'(ROW_MAX))) begin
            row = 6'(ROW_MAX);
        end else begin
            row = row_s[5:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            e_valid_reg   <= d_valid_reg;
            f_valid_reg   <= e_valid_reg;
            out_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_tag_reg      <= in_tag;
            a_silent_reg   <= (in_sum == '0);
            a_coarse_reg   <= coarse;
            a_grp_reg      <= grp;
            a_lp_reg       <= lp;
            a_lfrac_reg    <= lx[LEN_BITS+18 -: 20];

            b_tag_reg      <= a_tag_reg;
            b_silent_reg   <= a_silent_reg;
            b_p_reg        <= {a_grp_reg, bpos};
            b_sfrac_reg    <= norm[NW-2 -: 20];
            b_lp_reg       <= a_lp_reg;
            b_lfrac_reg    <= a_lfrac_reg;

            c_tag_reg      <= b_tag_reg;
            c_silent_reg   <= b_silent_reg;
            c_p_reg        <= b_p_reg;
            c_lp_reg       <= b_lp_reg;
            c_fs_reg       <= frac_interp(b_sfrac_reg);
            c_fl_reg       <= frac_interp(b_lfrac_reg);

            d_tag_reg      <= c_tag_reg;
            d_silent_reg   <= c_silent_reg;
            d_diff_reg     <= diff;

            e_tag_reg      <= d_tag_reg;
            e_silent_reg   <= d_silent_reg;
            e_prod_reg     <= d_diff_reg * k_s;

            f_tag_reg      <= e_tag_reg;
            f_silent_reg   <= e_silent_reg;
            f_level_reg    <= level;

            out_result_reg.level_db <= f_level_reg;
            out_result_reg.loud     <= (f_level_reg > cfg_loud_threshold);
            out_result_reg.silent   <= f_silent_reg;
            out_result_reg.bar_row  <= row;
            out_result_reg.tag      <= f_tag_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

`default_nettype wire

FILE: design/chunk_rms_db_meter_core.sv
// chunk_rms_db_meter_core: chunked rms level meter with a 1/16 dB output
//
// samples enter on the s_ stream, one transaction per sample, and one
// result per chunk of chunk_len samples leaves on the m_ stream. a result
// carries the level 10*log10(sum of squares / chunk_len) in 1/16 dB
// (saturated, -2048 for an all-zero chunk), the loud and silent flags, the
// display bar row and the chunk position in its block (tlast on the final
// chunk of a block).
// throughput is one sample per cycle while s_tready is high, with a chunk of
// any length down to one sample. the last sample of a chunk is squared into
// a register, the closed chunk sum enters the chunk queue and then passes a
// six-stage log pipeline and the output register to m_tvalid. when m_tready
// is low the pipeline holds, the chunk queue (4 entries) fills, and s_tready
// drops once one queue entry is left free. reset clears the sums, counters
// and all valid flags and loads the register defaults. the user must write
// registers over apb only while the block is idle, which it does not enforce.
// depends on crdm_pkg, crdm_front, crdm_fifo, crdm_back
`default_nettype none

module chunk_rms_db_meter_core import crdm_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int LEN_BITS    = 12
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [APB_ADDR_W-1:0]               paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // sample
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // level_db [11:0], bar_row [17:12], chunk_index [25:18], zeros above
    output logic [31:0]                              m_tdata,
    // loud [0], silent [1]
    output logic [1:0]                               m_tuser,
    output logic                                     m_tlast
);

    localparam int SUM_W = 2 * SAMPLE_BITS + LEN_BITS;

    logic [LEN_BITS-1:0] chunk_len_reg;
    logic [7:0]          chunks_per_block_reg;
    logic signed [11:0]  loud_threshold_reg;

    logic                cfg_write;
    logic [1:0]          reg_index;

    logic                queue_afull;
    logic                push_valid;
    logic [SUM_W-1:0]    push_sum;
    chunk_tag_t          push_tag;

    logic                pop_valid;
    logic                pop_ready;
    logic [SUM_W+8:0]    pop_data;
    logic [SUM_W-1:0]    pop_sum;
    chunk_tag_t          pop_tag;

    level_result_t       result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_len_reg        <= LEN_BITS'(CHUNK_LEN_RESET);
            chunks_per_block_reg <= 8'(CPB_RESET);
            loud_threshold_reg   <= 12'(THRESHOLD_RESET);
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_CHUNK_LEN:        chunk_len_reg        <= pwdata[LEN_BITS-1:0];
                REG_CHUNKS_PER_BLOCK: chunks_per_block_reg <= pwdata[7:0];
                REG_LOUD_THRESHOLD:   loud_threshold_reg   <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_CHUNK_LEN:        prdata = 32'(chunk_len_reg);
            REG_CHUNKS_PER_BLOCK: prdata = 32'(chunks_per_block_reg);
            REG_LOUD_THRESHOLD:   prdata = 32'(unsigned'(loud_threshold_reg));
            default:              prdata = 32'h0;
        endcase
    end

    crdm_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .LEN_BITS    (LEN_BITS)
    ) u_front (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .in_valid             (s_tvalid),
        .in_sample            (s_tdata[SAMPLE_BITS-1:0]),
        .in_ready             (s_tready),
        .cfg_chunk_len        (chunk_len_reg),
        .cfg_chunks_per_block (chunks_per_block_reg),
        .queue_afull          (queue_afull),
        .push_valid           (push_valid),
        .push_sum             (push_sum),
        .push_tag             (push_tag)
    );

    crdm_fifo #(
        .WIDTH (SUM_W + 9),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_valid    (push_valid),
        .wr_data     ({push_tag, push_sum}),
        .rd_ready    (pop_ready),
        .rd_valid    (pop_valid),
        .rd_data     (pop_data),
        .almost_full (queue_afull)
    );

    assign pop_sum = pop_data[SUM_W-1:0];
    assign pop_tag = pop_data[SUM_W+8:SUM_W];

    crdm_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .LEN_BITS    (LEN_BITS)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .in_valid           (pop_valid),
        .in_sum             (pop_sum),
        .in_tag             (pop_tag),
        .in_ready           (pop_ready),
        .cfg_chunk_len      (chunk_len_reg),
        .cfg_loud_threshold (loud_threshold_reg),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_result         (result)
    );

    assign m_tdata = {6'b000000, result.tag.index, result.bar_row, result.level_db};
    assign m_tuser = {result.silent, result.loud};
    assign m_tlast = result.tag.last;

endmodule

`default_nettype wire

FILE: design/crdm_checker.sv
// port-level checks on the result stream of the chunk level meter, bound to the top
// depends on chunk_rms_db_meter_core_assert.svh and chunk_rms_db_meter_core
`default_nettype none
`include "chunk_rms_db_meter_core_assert.svh"

module crdm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // a stalled transaction stays offered with the same content
    `CRDM_ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

    // nothing is offered in the cycle after a reset edge
    `CRDM_ASSERT_NEXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_tvalid, "result offered after reset")

    // a silent chunk reads as floor level, bottom row, never loud
    `CRDM_ASSERT_NOW(a_silent_floor, aclk, aresetn, m_tvalid && m_tuser[1], m_tdata[11:0] == 12'h800 && m_tdata[17:12] == 6'd63 && !m_tuser[0], "silent chunk with wrong level")

    // the bar row sits on the side of the center that the level sign gives
    `CRDM_ASSERT_NOW(a_row_side, aclk, aresetn, m_tvalid, (m_tdata[11] && m_tdata[17:12] >= 6'd30) || (!m_tdata[11] && m_tdata[17:12] <= 6'd30), "bar row on wrong side of center")

endmodule

bind chunk_rms_db_meter_core crdm_checker u_crdm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
